// ===== sv/nss_pkg.sv =====
// Shared types, sizes and the sequencer microprogram for the substring search core.
// No dependencies; every other file but nss_ram imports this package.
`default_nettype none

package nss_pkg;

  localparam int MAX_LEN = 255;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] match_position;
    logic       overflow;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRY,
    ST_TRY2,
    ST_CMP,
    ST_CHK,
    ST_RD,
    ST_ADV,
    ST_HIT,
    ST_MISS
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_GO,
    C_NOFIT,
    C_MZERO,
    C_NE,
    C_KLAST
  } cond_t;

  typedef struct packed {
    logic go;
    logic nofit;
    logic mzero;
    logic ne;
    logic klast;
  } cond_flags_t;

  typedef struct packed {
    logic  init;
    logic  s_inc;
    logic  k_inc;
    logic  k_clr;
    logic  rd_en;
    logic  emit;
    logic  hit;
    cond_t cond;
    step_t jump;
    step_t nxt;
  } ctrl_t;

  // Microprogram: one control word per step; jump taken when cond holds.
  function automatic ctrl_t ucode(step_t st);
    ctrl_t w;
    w = '{init: 1'b0, s_inc: 1'b0, k_inc: 1'b0, k_clr: 1'b0, rd_en: 1'b0,
          emit: 1'b0, hit: 1'b0, cond: C_ALWAYS, jump: ST_IDLE, nxt: ST_IDLE};
    case (st)
      ST_IDLE: begin
        w.init = 1'b1; w.cond = C_GO;    w.jump = ST_TRY;  w.nxt = ST_IDLE;
      end
      ST_TRY: begin
        w.cond = C_NOFIT; w.jump = ST_MISS; w.nxt = ST_TRY2;
      end
      ST_TRY2: begin
        w.rd_en = 1'b1; w.cond = C_MZERO; w.jump = ST_HIT; w.nxt = ST_CMP;
      end
      ST_CMP: begin
        w.cond = C_NE; w.jump = ST_ADV; w.nxt = ST_CHK;
      end
      ST_CHK: begin
        w.k_inc = 1'b1; w.cond = C_KLAST; w.jump = ST_HIT; w.nxt = ST_RD;
      end
      ST_RD: begin
        w.rd_en = 1'b1; w.cond = C_ALWAYS; w.jump = ST_CMP; w.nxt = ST_CMP;
      end
      ST_ADV: begin
        w.s_inc = 1'b1; w.k_clr = 1'b1; w.cond = C_ALWAYS; w.jump = ST_TRY; w.nxt = ST_TRY;
      end
      ST_HIT: begin
        w.emit = 1'b1; w.hit = 1'b1; w.cond = C_ALWAYS; w.jump = ST_IDLE; w.nxt = ST_IDLE;
      end
      ST_MISS: begin
        w.emit = 1'b1; w.cond = C_ALWAYS; w.jump = ST_IDLE; w.nxt = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.jump = ST_IDLE; w.nxt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/nss_seq.sv =====
// Microcoded sequencer: step register, control ROM lookup and condition select.
// Depends on nss_pkg.
`default_nettype none

module nss_seq (
  input  logic                clk,
  input  logic                rst,
  input  nss_pkg::cond_flags_t flags,
  output nss_pkg::ctrl_t      ctrl,
  output logic                busy
);
  import nss_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode(step);
    case (ctrl.cond)
      C_ALWAYS: taken = 1'b1;
      C_GO:     taken = flags.go;
      C_NOFIT:  taken = flags.nofit;
      C_MZERO:  taken = flags.mzero;
      C_NE:     taken = flags.ne;
      C_KLAST:  taken = flags.klast;
      default:  taken = 1'b1;
    endcase
    step_next = taken ? ctrl.jump : ctrl.nxt;
    busy      = (step != ST_IDLE);
  end

endmodule

`default_nettype wire

// ===== sv/naive_substring_search_core.sv =====
// Top level of the brute-force substring search core: byte loading, stores, search datapath.
// Depends on nss_pkg, nss_ram and nss_seq.
//
//   channel  | dir | handshake                | payload
//   ---------+-----+--------------------------+-------------------------------
//   item     | in  | start & !busy            | func, ch, last (nss_pkg::in_t)
//   result   | out | done, one cycle, no hold | match_position, overflow (out_t)
//
// A pattern byte, or a text byte without last, is taken without a stall and busy stays low.
// A text byte with last starts the search: at each start position the sequencer checks
// that the pattern still fits, then compares it byte by byte and moves on at the first
// mismatch; a full match or an empty pattern is a hit, running out of start positions is
// a miss, and either gives the result. busy stalls the input throughout, and the sequencer
// walks one byte per compare through the single read port of each store.
// Reset (rst, synchronous) empties both lengths and the flags; store contents are kept.
// Results cannot be stalled: done marks the single cycle in which result is valid.
`default_nettype none

module naive_substring_search_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  nss_pkg::in_t   item,
  output logic           busy,
  output logic           done,
  output nss_pkg::out_t  result
);
  import nss_pkg::*;

  // Load-side state.
  logic [LEN_W-1:0] text_length;
  logic [LEN_W-1:0] text_length_next;
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] pattern_length_next;
  logic             pattern_complete;
  logic             pattern_complete_next;
  logic             dropped_flag;
  logic             dropped_flag_next;

  // Search counters: s = attempt start, k = offset within the pattern.
  logic [LEN_W-1:0] s;
  logic [LEN_W-1:0] s_next;
  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] k_next;

  logic             accept;
  logic [LEN_W-1:0] pidx;
  logic             t_we;
  logic             p_we;
  logic [LEN_W-1:0] tsum;
  logic [LEN_W:0]   fit_sum;
  logic [LEN_W:0]   k_plus;
  logic [7:0]       t_rdata;
  logic [7:0]       p_rdata;

  cond_flags_t flags;
  ctrl_t       ctrl;

  assign accept = start && !busy;
  // A fresh pattern after a completed one restarts at entry zero.
  assign pidx   = pattern_complete ? '0 : pattern_length;
  assign t_we   = accept && !item.func && (text_length < LEN_W'(MAX_LEN));
  assign p_we   = accept && item.func && (pidx < LEN_W'(MAX_LEN));
  assign tsum   = s + k;

  nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (text_length[ADDR_W-1:0]),
    .wdata (item.ch),
    .re    (ctrl.rd_en),
    .raddr (tsum[ADDR_W-1:0]),
    .rdata (t_rdata)
  );

  nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pattern_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pidx[ADDR_W-1:0]),
    .wdata (item.ch),
    .re    (ctrl.rd_en),
    .raddr (k[ADDR_W-1:0]),
    .rdata (p_rdata)
  );

  // Sequencer condition inputs.
  always_comb begin
    fit_sum     = {1'b0, s} + {1'b0, pattern_length};
    k_plus      = {1'b0, k} + {{LEN_W{1'b0}}, 1'b1};
    flags.go    = accept && !item.func && item.last;
    flags.nofit = fit_sum > {1'b0, text_length};
    flags.mzero = (pattern_length == '0);
    flags.ne    = (t_rdata != p_rdata);
    flags.klast = (k_plus == {1'b0, pattern_length});
  end

  nss_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  always_comb begin
    text_length_next      = text_length;
    pattern_length_next   = pattern_length;
    pattern_complete_next = pattern_complete;
    dropped_flag_next     = dropped_flag;
    s_next                = s;
    k_next                = k;

    if (accept) begin
      if (item.func) begin
        pattern_length_next   = p_we ? pidx + 1'b1 : pidx;
        pattern_complete_next = item.last;
        if (!p_we) begin
          dropped_flag_next = 1'b1;
        end
      end else begin
        if (t_we) begin
          text_length_next = text_length + 1'b1;
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
    end

    if (ctrl.init) begin
      s_next = '0;
      k_next = '0;
    end
    if (ctrl.s_inc) begin
      s_next = s + 1'b1;
    end
    if (ctrl.k_clr) begin
      k_next = '0;
    end
    if (ctrl.k_inc) begin
      k_next = k + 1'b1;
    end

    // Text store empties after each search; the pattern stays.
    if (ctrl.emit) begin
      text_length_next  = '0;
      dropped_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length      <= '0;
      pattern_length   <= '0;
      pattern_complete <= 1'b0;
      dropped_flag     <= 1'b0;
      s                <= '0;
      k                <= '0;
    end else begin
      text_length      <= text_length_next;
      pattern_length   <= pattern_length_next;
      pattern_complete <= pattern_complete_next;
      dropped_flag     <= dropped_flag_next;
      s                <= s_next;
      k                <= k_next;
    end
  end

  // Position is s+1; s stays below the text length, so it fits in 8 bits.
  always_comb begin
    done                  = ctrl.emit;
    result.match_position = ctrl.hit ? 8'(s + 1'b1) : 8'd0;
    result.overflow       = dropped_flag;
  end

endmodule

`default_nettype wire

// ===== sv/nss_checker.sv =====
// Port-level checker for the substring search core, bound to the top level.
// Depends on nss_pkg and naive_substring_search_core.
`default_nettype none

module nss_port_props (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input nss_pkg::in_t  item,
  input logic          busy,
  input logic          done,
  input nss_pkg::out_t result
);
  import nss_pkg::*;

  logic search_go;
  logic load_only;

  assign search_go = start && !busy && !item.func && item.last;
  assign load_only = start && !busy && (item.func || !item.last);

  // A search transaction makes the core busy in the next cycle, with no result yet.
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    search_go |=> busy && !done)
    else $error("search did not start");

  // Loading a byte never produces a result or stalls the input.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_only |=> !busy && !done)
    else $error("load transaction stalled or produced a result");

  // A result only appears while a search is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result outside a search");

  // After a result the core is ready again at once.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("core not ready after result");

endmodule

bind naive_substring_search_core nss_port_props u_nss_port_props (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== tb/sv/nss_checker.sv =====
// Checker for the substring search core: keeps its own copy of the text and
// pattern stores, predicts each search result and compares what done delivers.
// Depends on nss_pkg (in_t, out_t, MAX_LEN).

module nss_checker
  import nss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  item,
  input  logic busy,
  input  logic done,
  input  out_t result,
  output int   errors,
  output int   outstanding,
  output int   searches,
  output int   found,
  output int   spilled
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] text_bytes [MAX_LEN];
  logic [7:0] pat_bytes  [MAX_LEN];
  int         text_len;
  int         pat_len;
  logic       pat_closed;
  logic       spill;

  out_t       positions_due [$];
  out_t       want;
  int         fail_cnt;
  int         search_cnt;
  int         found_cnt;
  int         spill_cnt;

  initial begin
    errors      = 0;
    outstanding = 0;
    searches    = 0;
    found       = 0;
    spilled     = 0;
    fail_cnt    = 0;
    search_cnt  = 0;
    found_cnt   = 0;
    spill_cnt   = 0;
    text_len    = 0;
    pat_len     = 0;
    pat_closed  = 1'b0;
    spill       = 1'b0;
  end

  // Brute force: first start offset where the whole pattern matches, 1-based.
  function automatic logic [7:0] first_match_pos();
    int s;
    int k;
    if (pat_len > text_len) return 8'd0;
    for (s = 0; s + pat_len <= text_len; s++) begin
      for (k = 0; k < pat_len; k++) begin
        if (text_bytes[s + k] != pat_bytes[k]) break;
      end
      if (k == pat_len) return 8'(s + 1);
    end
    return 8'd0;
  endfunction

  task automatic take_byte(input in_t t);
    out_t r;
    if (t.func) begin
      if (pat_closed) begin
        pat_len    = 0;
        pat_closed = 1'b0;
      end
      if (pat_len < MAX_LEN) begin
        pat_bytes[pat_len] = t.ch;
        pat_len++;
      end else begin
        spill = 1'b1;
      end
      if (t.last) pat_closed = 1'b1;
    end else begin
      if (text_len < MAX_LEN) begin
        text_bytes[text_len] = t.ch;
        text_len++;
      end else begin
        spill = 1'b1;
      end
      if (t.last) begin
        r.match_position = first_match_pos();
        r.overflow       = spill;
        positions_due.push_back(r);
        text_len = 0;
        spill    = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      text_len   = 0;
      pat_len    = 0;
      pat_closed = 1'b0;
      spill      = 1'b0;
      positions_due.delete();
    end else begin
      // a result leaving and a new transaction entering never share an edge, as done only comes while busy;
      // the result always belongs to an earlier search
      if (done) begin
        if (positions_due.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: match_position %0d overflow %0b",
                   $time, result.match_position, result.overflow);
        end else begin
          want = positions_due.pop_front();
          search_cnt++;
          if (result.match_position != 8'd0) found_cnt++;
          if (result.overflow) spill_cnt++;
          if (result.match_position !== want.match_position) begin
            fail_cnt++;
            $display("%0t: match_position expected %0d actual %0d",
                     $time, want.match_position, result.match_position);
          end
          if (result.overflow !== want.overflow) begin
            fail_cnt++;
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, result.overflow);
          end
        end
      end
      if (start && !busy) take_byte(item);
    end
    errors      <= fail_cnt;
    outstanding <= positions_due.size();
    searches    <= search_cnt;
    found       <= found_cnt;
    spilled     <= spill_cnt;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the substring search core testbench: clock, reset, byte stimulus and verdict.
// Depends on nss_pkg, naive_substring_search_core and nss_checker.

module tb_top;
  import nss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] bytes_t [$];

  // No transaction and no result for this many cycles means the core hung.
  // Longest correct search here is a full 255-byte text against a 1-byte
  // pattern; sender gaps are far shorter.
  localparam int HANG_LIMIT = 8000;
  localparam int RANDOM_BYTES = 450;
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst;
  logic start;
  in_t  item;
  logic busy;
  logic done;
  out_t result;

  int errors;
  int outstanding;
  int searches;
  int found;
  int spilled;

  // Stimulus-side view of the pattern, only used to plant matches in text.
  logic [7:0] pat_seen [$];
  logic       pat_closed;
  logic [7:0] alpha_base;
  int         alpha_n;
  int         burst_left;
  int         bytes_sent;
  int         idle_cycles;

  naive_substring_search_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  nss_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .searches    (searches),
    .found       (found),
    .spilled     (spilled)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hang detector: counts edges where neither a transaction nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still due",
                 $time, HANG_LIMIT, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Bytes mostly come from a small alphabet so that partial matches and
  // backtracking happen often; now and then a fully random byte slips in.
  function automatic logic [7:0] alpha_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return alpha_base + 8'($urandom_range(0, alpha_n - 1));
  endfunction

  function automatic void new_alphabet();
    alpha_base = 8'($urandom);
    alpha_n    = $urandom_range(1, 3);
  endfunction

  // One transaction. Called at a rising edge; returns at the edge that took it.
  // The sender runs in bursts: between bursts start drops for a random gap,
  // and a zero gap keeps start high straight through.
  task automatic push_byte(input logic f, input logic [7:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    item  <= '{func: f, ch: c, last: l};
    do @(posedge clk); while (busy);
    bytes_sent++;
    // track the pattern the same way the core does, for planting only
    if (f) begin
      if (pat_closed) begin
        pat_seen.delete();
        pat_closed = 1'b0;
      end
      if (pat_seen.size() < MAX_LEN) pat_seen.push_back(c);
      if (l) pat_closed = 1'b1;
    end
  endtask

  // A run of text or pattern bytes; close puts last on the final byte.
  task automatic send_run(input logic f, input bytes_t b, input logic close);
    foreach (b[i]) push_byte(f, b[i], close && (i == b.size() - 1));
  endtask

  initial begin
    bytes_t run;
    int     len;
    int     pos;
    int     kind;
    int     goal;

    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    pat_closed = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    new_alphabet();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // nothing loaded as pattern yet: an empty pattern matches at 1
    run = '{8'h00};
    send_run(1'b0, run, 1'b1);
    // two-byte pattern against one text byte: longer than text, gives 0
    run = '{8'hFF, 8'h00};
    send_run(1'b1, run, 1'b1);
    run = '{8'h00};
    send_run(1'b0, run, 1'b1);
    // same pattern found one byte in
    run = '{8'h12, 8'hFF, 8'h00};
    send_run(1'b0, run, 1'b1);
    // a new pattern replaces the closed one; left open, it is still searched
    run = '{8'h61, 8'h62};
    send_run(1'b1, run, 1'b0);
    run = '{8'h78, 8'h61, 8'h62};
    send_run(1'b0, run, 1'b1);
    // an open pattern keeps growing across a search
    run = '{8'h63};
    send_run(1'b1, run, 1'b0);
    run = '{8'h61, 8'h62, 8'h61};
    send_run(1'b0, run, 1'b1);
    run = '{8'h64};
    send_run(1'b1, run, 1'b1);
    run = '{8'h7A, 8'h61, 8'h62, 8'h63, 8'h64};
    send_run(1'b0, run, 1'b1);
    // mismatch late in an attempt forces a step back
    run = '{8'h61, 8'h61, 8'h62};
    send_run(1'b1, run, 1'b1);
    run = '{8'h61, 8'h61, 8'h61, 8'h62};
    send_run(1'b0, run, 1'b1);

    // ---- capacity ----
    // 256 pattern bytes: the last one is dropped, the full 255 are kept and
    // match a 255-byte text at position 1 with overflow set
    run.delete();
    repeat (256) run.push_back(8'($urandom));
    send_run(1'b1, run, 1'b1);
    run = run[0:MAX_LEN - 1];
    send_run(1'b0, run, 1'b1);
    // single-byte pattern sitting in the last stored text slot; the 256th
    // text byte is dropped but still starts the search -> position 255
    run = '{8'hA5};
    send_run(1'b1, run, 1'b1);
    run.delete();
    repeat (256) begin
      run.push_back(8'($urandom));
      if (run[$] == 8'hA5) run[$] = 8'h5A;
    end
    run[MAX_LEN - 1] = 8'hA5;
    send_run(1'b0, run, 1'b1);

    // ---- random ----
    // Mostly well-formed pattern/text pairs with planted matches; the rest is
    // stray text bytes that pile onto the next search and pattern fragments.
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      kind = $urandom_range(0, 9);
      run.delete();
      if (kind <= 1) begin
        if ($urandom_range(0, 2) == 0) new_alphabet();
        len = $urandom_range(1, 6);
        repeat (len) run.push_back(alpha_byte());
        send_run(1'b1, run, $urandom_range(0, 4) != 0);
      end else if (kind <= 7) begin
        len = $urandom_range(1, 24);
        repeat (len) run.push_back(alpha_byte());
        if (pat_seen.size() > 0 && pat_seen.size() <= len && $urandom_range(0, 2) != 0) begin
          pos = $urandom_range(0, len - pat_seen.size());
          foreach (pat_seen[i]) run[pos + i] = pat_seen[i];
        end
        send_run(1'b0, run, 1'b1);
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        repeat (len) run.push_back(8'($urandom));
        send_run(1'b0, run, 1'b0);
      end else begin
        len = $urandom_range(1, 2);
        repeat (len) run.push_back(alpha_byte());
        send_run(1'b1, run, 1'($urandom_range(0, 1)));
      end
    end
    // close out any stray text so every byte ends in a search
    push_byte(1'b0, alpha_byte(), 1'b1);
    start <= 1'b0;

    // ---- drain ----
    // checker counts are registered, so they lag the last transaction
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; %0d searches checked, %0d with a match,", bytes_sent,
             searches, found);
    $display("%0d with dropped bytes reported.", spilled);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
